[design/bnc_pkg.sv]
package bnc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int KIND_W      = 2;
    localparam int SYM_W       = 8;
    localparam int SCORE_W     = 64;
    localparam int STATUS_W    = 2;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_BALANCED   = 2'd0;
    localparam t_status ST_INCOMPLETE = 2'd1;
    localparam t_status ST_CORRUPTED  = 2'd2;
    localparam t_status ST_OVERFLOW   = 2'd3;

    localparam logic [SYM_W-1:0] CH_ROUND_OPEN  = 8'h28;
    localparam logic [SYM_W-1:0] CH_ROUND_CLOSE = 8'h29;
    localparam logic [SYM_W-1:0] CH_SQUARE_OPEN  = 8'h5B;
    localparam logic [SYM_W-1:0] CH_SQUARE_CLOSE = 8'h5D;
    localparam logic [SYM_W-1:0] CH_CURLY_OPEN  = 8'h7B;
    localparam logic [SYM_W-1:0] CH_CURLY_CLOSE = 8'h7D;
    localparam logic [SYM_W-1:0] CH_ANGLE_OPEN  = 8'h3C;
    localparam logic [SYM_W-1:0] CH_ANGLE_CLOSE = 8'h3E;

    localparam t_kind KIND_ROUND  = 2'd0;
    localparam t_kind KIND_SQUARE = 2'd1;
    localparam t_kind KIND_CURLY  = 2'd2;
    localparam t_kind KIND_ANGLE  = 2'd3;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_decode;

    function automatic t_decode decode_opener(input logic [SYM_W-1:0] c);
        t_decode d;
        d.hit = 1'b1;
        case (c)
            CH_ROUND_OPEN:  d.kind = KIND_ROUND;
            CH_SQUARE_OPEN: d.kind = KIND_SQUARE;
            CH_CURLY_OPEN:  d.kind = KIND_CURLY;
            CH_ANGLE_OPEN:  d.kind = KIND_ANGLE;
            default: begin
                d.hit  = 1'b0;
                d.kind = KIND_ROUND;
            end
        endcase
        return d;
    endfunction

    function automatic t_decode decode_closer(input logic [SYM_W-1:0] c);
        t_decode d;
        d.hit = 1'b1;
        case (c)
            CH_ROUND_CLOSE:  d.kind = KIND_ROUND;
            CH_SQUARE_CLOSE: d.kind = KIND_SQUARE;
            CH_CURLY_CLOSE:  d.kind = KIND_CURLY;
            CH_ANGLE_CLOSE:  d.kind = KIND_ANGLE;
            default: begin
                d.hit  = 1'b0;
                d.kind = KIND_ROUND;
            end
        endcase
        return d;
    endfunction

endpackage

[design/bnc_ram.sv]
module bnc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bracket_nesting_checker_top.sv]
// Channel | Dir | Signals               | Word contents (lowest bit up)
// s_axis  | in  | tvalid tready tdata   | tdata[7:0] symbol, tlast = line_end
//         |     | tlast                 |
// m_axis  | out | tvalid tready tdata   | tdata[63:0] completion_score,
//         |     | tuser                 | tuser[1:0] line_status
//
// For each character the accept cycle issues a read of the stack top from
// the kind memory, and the next cycle checks it and pushes or pops.
// A line end that leaves open brackets walks the memory one entry a cycle,
// top first, before the result word is loaded.
// Reset is synchronous and clears level, line flags and handshake state; the
// kind memory is not cleared, as only entries pushed earlier are ever used.
// A result word waiting on m_axis only holds up the next line end.
module bracket_nesting_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] symbol
    input  logic        i_s_axis_tlast,   // line_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] completion_score
    output logic [1:0]  o_m_axis_tuser    // [1:0] line_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FOLD,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    // line tracking
    logic [bnc_pkg::LEVEL_W-1:0] r_lvl, n_lvl;
    logic                        r_cor, n_cor;
    logic                        r_ovf, n_ovf;

    // captured character
    logic [bnc_pkg::SYM_W-1:0]   r_sym, n_sym;
    logic                        r_last, n_last;

    // fold walk
    logic [bnc_pkg::ADDR_W-1:0]  r_idx, n_idx;
    logic [bnc_pkg::LEVEL_W-1:0] r_cnt, n_cnt;
    logic                        r_pend, n_pend;
    logic [bnc_pkg::SCORE_W-1:0] r_score, n_score;
    bnc_pkg::t_status            r_status, n_status;

    // output register
    logic                        r_out_valid, n_out_valid;
    logic [bnc_pkg::SCORE_W-1:0] r_out_data, n_out_data;
    bnc_pkg::t_status            r_out_user, n_out_user;

    // memory port
    logic                        w_we;
    logic [bnc_pkg::ADDR_W-1:0]  w_waddr;
    bnc_pkg::t_kind              w_wdata;
    logic                        w_re;
    logic [bnc_pkg::ADDR_W-1:0]  w_raddr;
    bnc_pkg::t_kind              w_rdata;

    bnc_pkg::t_decode            w_open, w_close;
    logic                        w_s_acc;

    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_open  = bnc_pkg::decode_opener(r_sym);
    assign w_close = bnc_pkg::decode_closer(r_sym);

    bnc_ram #(
        .WIDTH(bnc_pkg::KIND_W),
        .DEPTH(bnc_pkg::STACK_DEPTH)
    ) u_kinds (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        logic [bnc_pkg::LEVEL_W-1:0] lv;
        logic                        cr;
        logic                        ov;

        n_state     = r_state;
        n_lvl       = r_lvl;
        n_cor       = r_cor;
        n_ovf       = r_ovf;
        n_sym       = r_sym;
        n_last      = r_last;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_score     = r_score;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        w_we    = 1'b0;
        w_waddr = r_lvl[bnc_pkg::ADDR_W-1:0];
        w_wdata = w_open.kind;
        w_re    = 1'b0;
        // top of stack; meaningless on an empty stack, where it goes unused
        w_raddr = bnc_pkg::ADDR_W'(r_lvl - 1'b1);

        lv = r_lvl;
        cr = r_cor;
        ov = r_ovf;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_sym   = i_s_axis_tdata;
                    n_last  = i_s_axis_tlast;
                    w_re    = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // a spoilt line ignores everything but its end
                if (!r_cor && !r_ovf) begin
                    if (w_open.hit) begin
                        if (r_lvl >= bnc_pkg::LEVEL_W'(bnc_pkg::STACK_DEPTH)) begin
                            ov = 1'b1;
                        end else begin
                            w_we = 1'b1;
                            lv   = r_lvl + 1'b1;
                        end
                    end else if (w_close.hit) begin
                        if (r_lvl == '0 || w_rdata != w_close.kind) begin
                            cr = 1'b1;
                        end else begin
                            lv = r_lvl - 1'b1;
                        end
                    end
                end
                n_lvl   = lv;
                n_cor   = cr;
                n_ovf   = ov;
                n_state = S_IDLE;
                if (r_last) begin
                    n_lvl   = '0;
                    n_cor   = 1'b0;
                    n_ovf   = 1'b0;
                    n_score = '0;
                    n_state = S_EMIT;
                    if (ov) begin
                        n_status = bnc_pkg::ST_OVERFLOW;
                    end else if (cr) begin
                        n_status = bnc_pkg::ST_CORRUPTED;
                    end else if (lv == '0) begin
                        n_status = bnc_pkg::ST_BALANCED;
                    end else begin
                        n_status = bnc_pkg::ST_INCOMPLETE;
                        n_idx    = bnc_pkg::ADDR_W'(lv - 1'b1);
                        n_cnt    = lv;
                        n_pend   = 1'b0;
                        n_state  = S_FOLD;
                    end
                end
            end
            S_FOLD: begin
                // read one entry a cycle, fold the one read the cycle before
                if (r_cnt != '0) begin
                    w_re    = 1'b1;
                    w_raddr = r_idx;
                    n_idx   = r_idx - 1'b1;
                    n_cnt   = r_cnt - 1'b1;
                end
                n_pend = (r_cnt != '0);
                if (r_pend) begin
                    n_score = (r_score << 2) + r_score
                              + bnc_pkg::SCORE_W'(w_rdata) + 64'd1;
                end
                if (r_cnt == '0 && !r_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_score;
                    n_out_user  = r_status;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= '0;
            r_cor       <= 1'b0;
            r_ovf       <= 1'b0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_cor       <= n_cor;
            r_ovf       <= n_ovf;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_sym      <= n_sym;
        r_last     <= n_last;
        r_idx      <= n_idx;
        r_score    <= n_score;
        r_status   <= n_status;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

[design/bnc_chk.sv]
module bnc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    logic w_s_acc;
    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result word valid after reset");

    // a pending result word stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
        && $stable(o_m_axis_tuser))
        else $error("result word dropped or changed while stalled");

    // only an incomplete line carries a score
    a_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != bnc_pkg::ST_INCOMPLETE
        |-> o_m_axis_tdata == '0)
        else $error("non-zero score on a line that is not incomplete");

    // no character is accepted while the stack update of the last one runs
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !o_s_axis_tready)
        else $error("character accepted on the update cycle");

    // a character that does not end its line yields no word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && !i_s_axis_tlast && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("result word without a line end");

endmodule

bind bracket_nesting_checker_top bnc_chk u_bnc_chk (.*);

[dv/tb_bracket_nesting_checker_top.sv]
module tb_bracket_nesting_checker_top;

    // Cycles with no word moving on either side before the run is abandoned.
    // Worst honest gap: the long receiver hold plus a full-depth fold.
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_WORD = 350;
    localparam int RANDOM_WORDS = 800;
    localparam int TAIL_CYCLES  = 100;

    typedef struct packed {
        bnc_pkg::t_status status;
        logic [63:0]      score;
    } t_line_result;

    typedef struct {
        logic [7:0] sym;
        logic       last;
        bit         drain;   // hold this word back until all results are in
    } t_char_item;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    bracket_nesting_checker_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [7:0] symbol
        .i_s_axis_tlast  (s_tlast),    // line_end
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [63:0] completion_score
        .o_m_axis_tuser  (m_tuser)     // [1:0] line_status
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Bracket stack tracker: own copy of the stack, level and line flags.
    // ------------------------------------------------------------------
    bnc_pkg::t_kind tracked_kinds [bnc_pkg::STACK_DEPTH];
    int             tracked_level = 0;
    bit             tracked_bad   = 1'b0;
    bit             tracked_full  = 1'b0;
    t_line_result   line_results_q[$];
    int             lines_predicted = 0;
    int             lines_checked   = 0;   // written by the result monitor only
    int             words_in        = 0;   // accepted input words
    int             mismatches      = 0;

    t_char_item     pending_chars[$];

    function automatic void decode_symbol(input logic [7:0] c, output bit opens,
                                          output bit closes, output bnc_pkg::t_kind k);
        opens  = 1'b0;
        closes = 1'b0;
        k      = bnc_pkg::KIND_ROUND;
        case (c)
            bnc_pkg::CH_ROUND_OPEN: begin
                opens = 1'b1;  k = bnc_pkg::KIND_ROUND;
            end
            bnc_pkg::CH_SQUARE_OPEN: begin
                opens = 1'b1;  k = bnc_pkg::KIND_SQUARE;
            end
            bnc_pkg::CH_CURLY_OPEN: begin
                opens = 1'b1;  k = bnc_pkg::KIND_CURLY;
            end
            bnc_pkg::CH_ANGLE_OPEN: begin
                opens = 1'b1;  k = bnc_pkg::KIND_ANGLE;
            end
            bnc_pkg::CH_ROUND_CLOSE: begin
                closes = 1'b1; k = bnc_pkg::KIND_ROUND;
            end
            bnc_pkg::CH_SQUARE_CLOSE: begin
                closes = 1'b1; k = bnc_pkg::KIND_SQUARE;
            end
            bnc_pkg::CH_CURLY_CLOSE: begin
                closes = 1'b1; k = bnc_pkg::KIND_CURLY;
            end
            bnc_pkg::CH_ANGLE_CLOSE: begin
                closes = 1'b1; k = bnc_pkg::KIND_ANGLE;
            end
            default: ;
        endcase
    endfunction

    // Applies one accepted character; on a line end queues the status word
    // the block must produce and clears the line.
    function automatic void track_symbol(input logic [7:0] c, input logic last);
        bit             opens;
        bit             closes;
        bnc_pkg::t_kind k;
        t_line_result   res;
        decode_symbol(c, opens, closes, k);
        // once a line is corrupted or overflowed only the line end matters
        if (!tracked_bad && !tracked_full) begin
            if (opens) begin
                if (tracked_level >= bnc_pkg::STACK_DEPTH) begin
                    tracked_full = 1'b1;    // the opener that did not fit is dropped
                end else begin
                    tracked_kinds[tracked_level] = k;
                    tracked_level++;
                end
            end else if (closes) begin
                if (tracked_level == 0 || tracked_kinds[tracked_level-1] != k)
                    tracked_bad = 1'b1;     // empty stack or wrong kind
                else
                    tracked_level--;
            end
        end
        if (last) begin
            res.score = '0;
            if (tracked_full) begin
                res.status = bnc_pkg::ST_OVERFLOW;
            end else if (tracked_bad) begin
                res.status = bnc_pkg::ST_CORRUPTED;
            end else if (tracked_level == 0) begin
                res.status = bnc_pkg::ST_BALANCED;
            end else begin
                res.status = bnc_pkg::ST_INCOMPLETE;
                // base-five fold from the top down, wrapping at 64 bits
                for (int i = tracked_level; i > 0; i--)
                    res.score = res.score * 64'd5 + 64'(tracked_kinds[i-1]) + 64'd1;
            end
            line_results_q.insert(line_results_q.size(), res);
            lines_predicted++;
            tracked_level = 0;
            tracked_bad   = 1'b0;
            tracked_full  = 1'b0;
        end
    endfunction

    function automatic void report_mismatch(input string field, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] opener_char(input bnc_pkg::t_kind k);
        case (k)
            bnc_pkg::KIND_ROUND:  return bnc_pkg::CH_ROUND_OPEN;
            bnc_pkg::KIND_SQUARE: return bnc_pkg::CH_SQUARE_OPEN;
            bnc_pkg::KIND_CURLY:  return bnc_pkg::CH_CURLY_OPEN;
            default:              return bnc_pkg::CH_ANGLE_OPEN;
        endcase
    endfunction

    function automatic logic [7:0] closer_char(input bnc_pkg::t_kind k);
        case (k)
            bnc_pkg::KIND_ROUND:  return bnc_pkg::CH_ROUND_CLOSE;
            bnc_pkg::KIND_SQUARE: return bnc_pkg::CH_SQUARE_CLOSE;
            bnc_pkg::KIND_CURLY:  return bnc_pkg::CH_CURLY_CLOSE;
            default:              return bnc_pkg::CH_ANGLE_CLOSE;
        endcase
    endfunction

    // Half raw bytes, half bracket characters of any kind.
    function automatic logic [7:0] any_symbol();
        if ($urandom_range(0, 1) != 0)
            return 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) != 0)
            return opener_char(bnc_pkg::t_kind'($urandom_range(0, 3)));
        return closer_char(bnc_pkg::t_kind'($urandom_range(0, 3)));
    endfunction

    // A byte that is no bracket at all.
    function automatic logic [7:0] filler_symbol();
        logic [7:0]     c;
        bit             opens;
        bit             closes;
        bnc_pkg::t_kind k;
        do begin
            c = 8'($urandom_range(0, 255));
            decode_symbol(c, opens, closes, k);
        end while (opens || closes);
        return c;
    endfunction

    task automatic put(input logic [7:0] c, input logic last);
        t_char_item ci;
        ci.sym   = c;
        ci.last  = last;
        ci.drain = 1'b0;
        pending_chars.insert(pending_chars.size(), ci);
    endtask

    // Properly nested content: pushes, matching pops and filler bytes.
    task automatic add_nested(ref logic [7:0] chars[$], ref bnc_pkg::t_kind open_q[$],
                              input int unsigned n);
        int unsigned    r;
        bnc_pkg::t_kind k;
        repeat (n) begin
            r = $urandom_range(0, 9);
            if (r < 4 || (r < 8 && open_q.size() == 0)) begin
                k = bnc_pkg::t_kind'($urandom_range(0, 3));
                open_q.insert(open_q.size(), k);
                chars.insert(chars.size(), opener_char(k));
            end else if (r < 8) begin
                chars.insert(chars.size(), closer_char(open_q.pop_back()));
            end else begin
                chars.insert(chars.size(), filler_symbol());
            end
        end
    endtask

    // One random line; returns the number of words queued.
    task automatic add_line(input bit drain, output int unsigned words);
        logic [7:0]     chars[$];
        bnc_pkg::t_kind open_q[$];
        bnc_pkg::t_kind k;
        int unsigned    style;
        int unsigned    n;
        t_char_item     ci;
        style = $urandom_range(0, 99);
        if (style < 55) begin
            // well formed, closed off half the time
            add_nested(chars, open_q, $urandom_range(1, 16));
            if ($urandom_range(0, 1) != 0)
                while (open_q.size() != 0)
                    chars.insert(chars.size(), closer_char(open_q.pop_back()));
        end else if (style < 75) begin
            // nested prefix, then a closer of the wrong kind, then junk
            add_nested(chars, open_q, $urandom_range(0, 8));
            if (open_q.size() == 0)
                k = bnc_pkg::t_kind'($urandom_range(0, 3));
            else
                k = open_q[open_q.size()-1] + bnc_pkg::t_kind'($urandom_range(1, 3));
            chars.insert(chars.size(), closer_char(k));
            n = $urandom_range(0, 6);
            repeat (n) chars.insert(chars.size(), any_symbol());
        end else if (style < 90) begin
            n = $urandom_range(1, 12);
            repeat (n) chars.insert(chars.size(), any_symbol());
        end else if (style < 98) begin
            chars.insert(chars.size(), any_symbol());
        end else begin
            // deep line: around and beyond a full stack
            case ($urandom_range(0, 3))
                0:       n = bnc_pkg::STACK_DEPTH - 1;
                1:       n = bnc_pkg::STACK_DEPTH;
                2:       n = bnc_pkg::STACK_DEPTH + 1;
                default: n = $urandom_range(40, bnc_pkg::STACK_DEPTH + 6);
            endcase
            repeat (n) begin
                k = bnc_pkg::t_kind'($urandom_range(0, 3));
                open_q.insert(open_q.size(), k);
                chars.insert(chars.size(), opener_char(k));
            end
            n = $urandom_range(0, 8);
            repeat (n) begin
                if ($urandom_range(0, 1) != 0 && open_q.size() != 0)
                    chars.insert(chars.size(), closer_char(open_q.pop_back()));
                else
                    chars.insert(chars.size(), any_symbol());
            end
        end
        foreach (chars[i]) begin
            ci.sym   = chars[i];
            ci.last  = (i == chars.size() - 1);
            ci.drain = (drain && i == 0);
            pending_chars.insert(pending_chars.size(), ci);
        end
        words = chars.size();
    endtask

    // ------------------------------------------------------------------
    // Input driver: bursts of words with random gaps; a word flagged for
    // draining waits until every outstanding status word has come back.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_char_item nxt;
        if (!rst_n) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_symbol(s_tdata, s_tlast);
                words_in <= words_in + 1;
            end
            // a word on offer and not taken stays put
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() == 0 ||
                             (pending_chars[0].drain && lines_checked < lines_predicted)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = pending_chars.pop_front();
                    s_tdata  <= nxt.sym;
                    s_tlast  <= nxt.last;
                    s_tvalid <= 1'b1;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern set by rx_cycle[9:8] in turn (always ready,
    // coin toss, one in four, mostly ready). Once, a long hold-off so the
    // pending status word blocks the next line end and the input backs up.
    // ------------------------------------------------------------------
    logic [31:0] rx_cycle  = '0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (!hold_done && words_in >= HOLD_AT_WORD) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_cycle[9:8])
                    2'd0:    m_tready <= 1'b1;
                    2'd1:    m_tready <= ($urandom_range(0, 1) == 0);
                    2'd2:    m_tready <= (rx_cycle[1:0] == 2'b00);
                    default: m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: each status word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_line_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (line_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("status word with none expected: status %0d, score %0d",
                             m_tuser, m_tdata);
            end else begin
                want = line_results_q.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("line_status", 64'(want.status), 64'(m_tuser));
                if (m_tdata !== want.score)
                    report_mismatch("completion_score", want.score, m_tdata);
            end
            lines_checked <= lines_checked + 1;
        end
    end

    // Watchdog: nothing moving on either side for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus build, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned random_words;
        int unsigned n;

        // every pair nested, closed in order; closer as last word
        put(bnc_pkg::CH_ROUND_OPEN, 1'b0);
        put(bnc_pkg::CH_SQUARE_OPEN, 1'b0);
        put(bnc_pkg::CH_CURLY_OPEN, 1'b0);
        put(bnc_pkg::CH_ANGLE_OPEN, 1'b0);
        put(bnc_pkg::CH_ANGLE_CLOSE, 1'b0);
        put(bnc_pkg::CH_CURLY_CLOSE, 1'b0);
        put(bnc_pkg::CH_SQUARE_CLOSE, 1'b0);
        put(bnc_pkg::CH_ROUND_CLOSE, 1'b1);
        // left open, all four kinds in the fold, opener as last word
        put(bnc_pkg::CH_ANGLE_OPEN, 1'b0);
        put(bnc_pkg::CH_CURLY_OPEN, 1'b0);
        put(bnc_pkg::CH_SQUARE_OPEN, 1'b0);
        put(bnc_pkg::CH_ROUND_OPEN, 1'b1);
        // extreme bytes, ignored, line end still honoured
        put(8'h00, 1'b0);
        put(8'hFF, 1'b1);
        // closer on an empty stack, then the rest of the line ignored
        put(bnc_pkg::CH_ROUND_CLOSE, 1'b0);
        put(bnc_pkg::CH_ROUND_OPEN, 1'b1);
        // wrong closer
        put(bnc_pkg::CH_ROUND_OPEN, 1'b0);
        put(bnc_pkg::CH_SQUARE_CLOSE, 1'b0);
        put(bnc_pkg::CH_SQUARE_OPEN, 1'b1);
        // single opener line
        put(bnc_pkg::CH_CURLY_OPEN, 1'b1);

        // random lines; the first one and a few others wait for a full drain
        random_words = 0;
        add_line(1'b1, n);
        random_words += n;
        while (random_words < RANDOM_WORDS) begin
            add_line($urandom_range(0, 32) == 0, n);
            random_words += n;
        end

        rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        do @(negedge i_clk); while (pending_chars.size() != 0 || s_tvalid);
        while (lines_checked < lines_predicted) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && line_results_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
design/bnc_pkg.sv
design/bnc_ram.sv
design/bracket_nesting_checker_top.sv
design/bnc_chk.sv
dv/tb_bracket_nesting_checker_top.sv
